FILE: rtl/slxd_pkg.sv
// Shared types, constants and helpers for the sync/length/XOR packet deframer.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package slxd_pkg;

  // Header layout
  localparam int unsigned HEADER_BYTES = 6;
  localparam int unsigned SIZE_OFFSET  = 4;
  localparam int unsigned HDR_IDX_W    = $clog2(HEADER_BYTES);

  // Legacy prefix bytes reported while hunting
  localparam logic [7:0] OLD_PREFIX_A = 8'hAB;
  localparam logic [7:0] OLD_PREFIX_B = 8'hBB;

  // Register map: register i sits at byte address 4*i
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned PADDR_W   = REG_IDX_W + 2;

  localparam logic [REG_IDX_W-1:0] REG_SYNC       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TYPE_DATA  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TYPE_DSTAT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TYPE_CSTAT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TYPE_RSTAT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MAX_LEN    = 3'd5;

  typedef enum logic [2:0] {
    EVT_GOOD       = 3'd0,
    EVT_BAD_SUM    = 3'd1,
    EVT_ZERO_LEN   = 3'd2,
    EVT_BAD_TYPE   = 3'd3,
    EVT_TOO_LONG   = 3'd4,
    EVT_DISCARD    = 3'd5,
    EVT_OLD_PREFIX = 3'd6
  } evt_e;

  typedef struct packed {
    logic [7:0]  sync_value;
    logic [7:0]  type_das_data;
    logic [7:0]  type_das_status;
    logic [7:0]  type_dc_status;
    logic [7:0]  type_rtx_status;
    logic [15:0] max_length;
  } cfg_t;

  typedef struct packed {
    evt_e        event_code;
    logic [7:0]  packet_type;
    logic [15:0] packet_length;
    logic [15:0] received_sum;
    logic [15:0] computed_sum;
    logic [7:0]  offending_byte;
  } res_t;

  // Even byte index is the high half of a big-endian word
  function automatic logic [15:0] place_byte(input logic odd, input logic [7:0] b);
    return odd ? {8'h00, b} : {b, 8'h00};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/slxd_cfg.sv
// APB-style register file for the deframer settings.
// Depends on slxd_pkg for the register map and the settings struct.
`default_nettype none

module slxd_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [slxd_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output slxd_pkg::cfg_t                     cfg_o
);

  slxd_pkg::cfg_t               cfg_q;
  logic [slxd_pkg::REG_IDX_W-1:0] idx;
  logic                         wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[slxd_pkg::PADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_value      <= 8'hDA;
      cfg_q.type_das_data   <= 8'hAB;
      cfg_q.type_das_status <= 8'hAC;
      cfg_q.type_dc_status  <= 8'hAD;
      cfg_q.type_rtx_status <= 8'hAE;
      cfg_q.max_length      <= 16'd4096;
    end else if (wr_en) begin
      unique case (idx)
        slxd_pkg::REG_SYNC:       cfg_q.sync_value      <= pwdata[7:0];
        slxd_pkg::REG_TYPE_DATA:  cfg_q.type_das_data   <= pwdata[7:0];
        slxd_pkg::REG_TYPE_DSTAT: cfg_q.type_das_status <= pwdata[7:0];
        slxd_pkg::REG_TYPE_CSTAT: cfg_q.type_dc_status  <= pwdata[7:0];
        slxd_pkg::REG_TYPE_RSTAT: cfg_q.type_rtx_status <= pwdata[7:0];
        slxd_pkg::REG_MAX_LEN:    cfg_q.max_length      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      slxd_pkg::REG_SYNC:       prdata = {24'h0, cfg_q.sync_value};
      slxd_pkg::REG_TYPE_DATA:  prdata = {24'h0, cfg_q.type_das_data};
      slxd_pkg::REG_TYPE_DSTAT: prdata = {24'h0, cfg_q.type_das_status};
      slxd_pkg::REG_TYPE_CSTAT: prdata = {24'h0, cfg_q.type_dc_status};
      slxd_pkg::REG_TYPE_RSTAT: prdata = {24'h0, cfg_q.type_rtx_status};
      slxd_pkg::REG_MAX_LEN:    prdata = {16'h0, cfg_q.max_length};
      default:                  prdata = 32'h0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/slxd_core.sv
// Per-byte framing engine: sync hunt, type check, header capture, length and
// running XOR checksum. Depends on slxd_pkg.
`default_nettype none

module slxd_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire slxd_pkg::cfg_t  cfg_i,
  input  wire logic            acc_i,
  input  wire logic [7:0]      byte_i,
  output logic                 res_vld_o,
  output slxd_pkg::res_t       res_o
);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_TYPE = 2'd1,
    PH_HEAD = 2'd2,
    PH_BODY = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] len_q, len_d;
  logic [15:0] xor_q, xor_d;
  logic [15:0] csum_q, csum_d;
  logic [7:0]  ptype_q, ptype_d;
  logic [7:0]  hdr_q [slxd_pkg::HEADER_BYTES];
  logic [7:0]  hdr_d [slxd_pkg::HEADER_BYTES];

  logic [16:0] cnt_nx;
  logic [7:0]  len_hi, len_lo;
  logic [15:0] hlen;
  logic [15:0] xinit;
  logic        type_ok;

  assign type_ok = (byte_i == cfg_i.type_das_data)   || (byte_i == cfg_i.type_das_status) ||
                   (byte_i == cfg_i.type_dc_status)  || (byte_i == cfg_i.type_rtx_status);
  assign cnt_nx  = {1'b0, cnt_q} + 17'd1;

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    xor_d     = xor_q;
    csum_d    = csum_q;
    ptype_d   = ptype_q;
    hdr_d     = hdr_q;
    res_vld_o = 1'b0;
    res_o     = '0;
    len_hi    = 8'h00;
    len_lo    = 8'h00;
    hlen      = 16'h0000;
    xinit     = 16'h0000;

    if (acc_i) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (byte_i == cfg_i.sync_value) begin
            hdr_d[0] = byte_i;
            cnt_d    = 16'd1;
            phase_d  = PH_TYPE;
          end else begin
            res_vld_o            = 1'b1;
            res_o.offending_byte = byte_i;
            if (byte_i == slxd_pkg::OLD_PREFIX_A || byte_i == slxd_pkg::OLD_PREFIX_B) begin
              res_o.event_code = slxd_pkg::EVT_OLD_PREFIX;
            end else begin
              res_o.event_code = slxd_pkg::EVT_DISCARD;
            end
          end
        end

        PH_TYPE: begin
          if (type_ok) begin
            hdr_d[1] = byte_i;
            ptype_d  = byte_i;
            cnt_d    = 16'd2;
            phase_d  = PH_HEAD;
          end else begin
            phase_d              = PH_HUNT;
            cnt_d                = 16'd0;
            res_vld_o            = 1'b1;
            res_o.event_code     = slxd_pkg::EVT_BAD_TYPE;
            res_o.packet_type    = byte_i;
            res_o.offending_byte = byte_i;
          end
        end

        PH_HEAD: begin
          for (int k = 0; k < slxd_pkg::HEADER_BYTES; k++) begin
            if (cnt_q[slxd_pkg::HDR_IDX_W-1:0] == slxd_pkg::HDR_IDX_W'(k)) begin
              hdr_d[k] = byte_i;
            end
          end
          cnt_d = cnt_nx[15:0];
          // Length bytes outside the header read as zero
          for (int k = 0; k < slxd_pkg::HEADER_BYTES; k++) begin
            if (k == slxd_pkg::SIZE_OFFSET)     len_hi = hdr_d[k];
            if (k == slxd_pkg::SIZE_OFFSET + 1) len_lo = hdr_d[k];
          end
          hlen  = {len_hi, len_lo};
          xinit = {hdr_d[0], hdr_d[1]};
          for (int k = 4; k < slxd_pkg::HEADER_BYTES; k++) begin
            if (16'(k) < hlen) begin
              xinit = xinit ^ slxd_pkg::place_byte(k[0], hdr_d[k]);
            end
          end
          if (cnt_nx == 17'(slxd_pkg::HEADER_BYTES)) begin
            len_d = hlen;
            if (hlen == 16'd0) begin
              phase_d           = PH_HUNT;
              cnt_d             = 16'd0;
              res_vld_o         = 1'b1;
              res_o.event_code  = slxd_pkg::EVT_ZERO_LEN;
              res_o.packet_type = ptype_q;
            end else begin
              csum_d  = {hdr_d[2], hdr_d[3]};
              xor_d   = xinit;
              phase_d = PH_BODY;
            end
          end
        end

        PH_BODY: begin
          if (cnt_q < len_q) begin
            xor_d = xor_q ^ slxd_pkg::place_byte(cnt_q[0], byte_i);
          end
          cnt_d = cnt_nx[15:0];
          // Completion wins over the length limit
          if (cnt_nx >= {1'b0, len_q}) begin
            phase_d             = PH_HUNT;
            cnt_d               = 16'd0;
            res_vld_o           = 1'b1;
            res_o.event_code    = (xor_d == csum_q) ? slxd_pkg::EVT_GOOD
                                                    : slxd_pkg::EVT_BAD_SUM;
            res_o.packet_type   = ptype_q;
            res_o.packet_length = len_q;
            res_o.received_sum  = csum_q;
            res_o.computed_sum  = xor_d;
          end else if (cnt_nx >= {1'b0, cfg_i.max_length}) begin
            phase_d             = PH_HUNT;
            cnt_d               = 16'd0;
            res_vld_o           = 1'b1;
            res_o.event_code    = slxd_pkg::EVT_TOO_LONG;
            res_o.packet_type   = ptype_q;
            res_o.packet_length = len_q;
          end
        end

        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cnt_q   <= 16'd0;
      len_q   <= 16'd0;
      xor_q   <= 16'd0;
      csum_q  <= 16'd0;
      ptype_q <= 8'd0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      xor_q   <= xor_d;
      csum_q  <= csum_d;
      ptype_q <= ptype_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
  end

endmodule

`default_nettype wire

FILE: rtl/slxd_obuf.sv
// Result register with one skid entry between the engine and the output
// stream. Depends on slxd_pkg for the result struct.
`default_nettype none

module slxd_obuf (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire slxd_pkg::res_t  res_i,
  output logic                 ready_o,
  output logic                 vld_o,
  input  wire logic            pop_rdy_i,
  output slxd_pkg::res_t       res_o
);

  logic           main_vld_q, skid_vld_q;
  slxd_pkg::res_t main_q, skid_q;
  logic           pop;

  assign pop     = main_vld_q & pop_rdy_i;
  assign ready_o = ~skid_vld_q;
  assign vld_o   = main_vld_q;
  assign res_o   = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!main_vld_q || pop) begin
        main_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (pop) begin
      main_vld_q <= 1'b0;
    end
  end

  // Payload moves without reset; the valid flags above qualify it
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (!main_vld_q || pop) begin
        main_q <= res_i;
      end else begin
        skid_q <= res_i;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sync_length_xor_packet_deframer.sv
// Byte-stream packet deframer: one received byte per transfer in, one event
// transfer out for each packet outcome or discarded byte. A byte is taken every
// clock while the output is drained; each byte passes combinationally through the
// framing engine and its event lands in the output register on the edge that
// takes the byte. A single skid entry holds one extra event, so input stalls
// only once two events wait on the output side. Packets begin with the sync byte,
// then a type byte that must match one of four codes, a six-byte header carrying
// a big-endian length at byte four, and a body counted up to that length.
// Depends on slxd_pkg, slxd_cfg, slxd_core and slxd_obuf.
`default_nettype none

module sync_length_xor_packet_deframer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // APB settings port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [slxd_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // Byte stream in
  input  wire logic                          s_tvalid_i,
  output logic                               s_tready_o,
  input  wire logic [7:0]                    s_tdata_i,  // in_byte
  // Event stream out
  output logic                               m_tvalid_o,
  input  wire logic                          m_tready_i,
  // packet_type[7:0], packet_length[23:8], received_sum[39:24],
  // computed_sum[55:40], offending_byte[63:56]
  output logic [63:0]                        m_tdata_o,
  output logic [2:0]                         m_tuser_o   // event_code
);

  slxd_pkg::cfg_t cfg;
  slxd_pkg::res_t core_res, out_res;
  logic           core_vld;
  logic           acc;

  assign acc = s_tvalid_i & s_tready_o;

  slxd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  slxd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .acc_i     (acc),
    .byte_i    (s_tdata_i),
    .res_vld_o (core_vld),
    .res_o     (core_res)
  );

  slxd_obuf u_obuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (core_vld),
    .res_i     (core_res),
    .ready_o   (s_tready_o),
    .vld_o     (m_tvalid_o),
    .pop_rdy_i (m_tready_i),
    .res_o     (out_res)
  );

  assign m_tuser_o = out_res.event_code;
  assign m_tdata_o = {out_res.offending_byte, out_res.computed_sum,
                      out_res.received_sum, out_res.packet_length,
                      out_res.packet_type};

endmodule

`default_nettype wire

FILE: dv/deframer_event_checker.sv
`timescale 1ns / 1ps
// Event checker for the sync/length/XOR packet deframer: mirrors register writes,
// predicts the event for every accepted stream byte and compares each event transfer.
// Depends on slxd_pkg.

module deframer_event_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [slxd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  input  logic                         pready,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [7:0]                   s_tdata_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic [63:0]                  m_tdata_i,
  input  logic [2:0]                   m_tuser_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o,
  output int unsigned                  checked_o
);

  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic [1:0] {SEEK_SYNC, READ_TYPE, READ_HEADER, READ_BODY} frame_phase_e;

  slxd_pkg::cfg_t cfg;
  frame_phase_e   phase;
  int unsigned    byte_count;
  logic [15:0]    length_value;
  logic [15:0]    running_xor;
  logic [15:0]    carried_sum;
  logic [7:0]     current_type;
  logic [7:0]     hdr_bytes [slxd_pkg::HEADER_BYTES];
  slxd_pkg::res_t expected_events [$];

  function automatic logic [7:0] hdr_byte(input int unsigned k);
    return (k < slxd_pkg::HEADER_BYTES) ? hdr_bytes[k] : 8'h00;
  endfunction

  function automatic logic is_accepted_type(input logic [7:0] b);
    return b == cfg.type_das_data || b == cfg.type_das_status ||
           b == cfg.type_dc_status || b == cfg.type_rtx_status;
  endfunction

  task automatic write_register(input logic [slxd_pkg::REG_IDX_W-1:0] idx,
                                input logic [31:0] v);
    case (idx)
      slxd_pkg::REG_SYNC:       cfg.sync_value      = v[7:0];
      slxd_pkg::REG_TYPE_DATA:  cfg.type_das_data   = v[7:0];
      slxd_pkg::REG_TYPE_DSTAT: cfg.type_das_status = v[7:0];
      slxd_pkg::REG_TYPE_CSTAT: cfg.type_dc_status  = v[7:0];
      slxd_pkg::REG_TYPE_RSTAT: cfg.type_rtx_status = v[7:0];
      slxd_pkg::REG_MAX_LEN:    cfg.max_length      = v[15:0];
      default: ;
    endcase
  endtask

  // Advance the framing state by one byte; queue the event it causes, if any.
  task automatic deframe_byte(input logic [7:0] b);
    slxd_pkg::res_t ev;
    logic           fire;
    int unsigned    idx;
    int unsigned    k;
    ev   = '0;
    fire = 1'b0;
    case (phase)
      SEEK_SYNC: begin
        if (b == cfg.sync_value) begin
          hdr_bytes[0] = b;
          byte_count   = 1;
          phase        = READ_TYPE;
        end else begin
          fire              = 1'b1;
          ev.event_code     = (b == slxd_pkg::OLD_PREFIX_A || b == slxd_pkg::OLD_PREFIX_B)
                              ? slxd_pkg::EVT_OLD_PREFIX : slxd_pkg::EVT_DISCARD;
          ev.offending_byte = b;
        end
      end
      READ_TYPE: begin
        if (is_accepted_type(b)) begin
          hdr_bytes[1] = b;
          current_type = b;
          byte_count   = 2;
          phase        = READ_HEADER;
        end else begin
          phase             = SEEK_SYNC;
          byte_count        = 0;
          fire              = 1'b1;
          ev.event_code     = slxd_pkg::EVT_BAD_TYPE;
          ev.packet_type    = b;
          ev.offending_byte = b;
        end
      end
      READ_HEADER: begin
        idx = byte_count;
        if (idx < slxd_pkg::HEADER_BYTES) hdr_bytes[idx] = b;
        byte_count = idx + 1;
        if (byte_count >= slxd_pkg::HEADER_BYTES) begin
          length_value = {hdr_byte(slxd_pkg::SIZE_OFFSET),
                          hdr_byte(slxd_pkg::SIZE_OFFSET + 1)};
          if (length_value == 16'h0000) begin
            phase          = SEEK_SYNC;
            byte_count     = 0;
            fire           = 1'b1;
            ev.event_code  = slxd_pkg::EVT_ZERO_LEN;
            ev.packet_type = current_type;
          end else begin
            carried_sum = {hdr_byte(2), hdr_byte(3)};
            running_xor = {hdr_byte(0), hdr_byte(1)};
            for (k = 4; k < slxd_pkg::HEADER_BYTES; k++) begin
              if (k < length_value)
                running_xor ^= k[0] ? {8'h00, hdr_byte(k)} : {hdr_byte(k), 8'h00};
            end
            phase = READ_BODY;
          end
        end
      end
      default: begin
        idx = byte_count;
        if (idx < length_value) running_xor ^= idx[0] ? {8'h00, b} : {b, 8'h00};
        byte_count = idx + 1;
        // completion wins over the length limit
        if (byte_count >= length_value) begin
          phase            = SEEK_SYNC;
          byte_count       = 0;
          fire             = 1'b1;
          ev.event_code    = (running_xor == carried_sum) ? slxd_pkg::EVT_GOOD
                                                          : slxd_pkg::EVT_BAD_SUM;
          ev.packet_type   = current_type;
          ev.packet_length = length_value;
          ev.received_sum  = carried_sum;
          ev.computed_sum  = running_xor;
        end else if (byte_count >= cfg.max_length) begin
          phase            = SEEK_SYNC;
          byte_count       = 0;
          fire             = 1'b1;
          ev.event_code    = slxd_pkg::EVT_TOO_LONG;
          ev.packet_type   = current_type;
          ev.packet_length = length_value;
        end
      end
    endcase
    if (fire) expected_events.push_back(ev);
  endtask

  task automatic compare_event();
    slxd_pkg::res_t exp_ev;
    logic           bad;
    checked_o++;
    if (expected_events.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= MAX_REPORTS)
        $display("%0t: unexpected event transfer: code %0d data %016h",
                 $time, m_tuser_i, m_tdata_i);
    end else begin
      exp_ev = expected_events.pop_front();
      bad = (m_tuser_i !== exp_ev.event_code) ||
            (m_tdata_i[7:0] !== exp_ev.packet_type) ||
            (m_tdata_i[23:8] !== exp_ev.packet_length) ||
            (m_tdata_i[39:24] !== exp_ev.received_sum) ||
            (m_tdata_i[55:40] !== exp_ev.computed_sum) ||
            (m_tdata_i[63:56] !== exp_ev.offending_byte);
      if (bad) begin
        fail_count_o++;
        if (fail_count_o <= MAX_REPORTS) begin
          $display({"%0t: event mismatch, expected code %0d type %02h len %04h",
                    " rsum %04h csum %04h off %02h"},
                   $time, exp_ev.event_code, exp_ev.packet_type, exp_ev.packet_length,
                   exp_ev.received_sum, exp_ev.computed_sum, exp_ev.offending_byte);
          $display({"%0t:                 got      code %0d type %02h len %04h",
                    " rsum %04h csum %04h off %02h"},
                   $time, m_tuser_i, m_tdata_i[7:0], m_tdata_i[23:8], m_tdata_i[39:24],
                   m_tdata_i[55:40], m_tdata_i[63:56]);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.sync_value      = 8'hDA;
      cfg.type_das_data   = 8'hAB;
      cfg.type_das_status = 8'hAC;
      cfg.type_dc_status  = 8'hAD;
      cfg.type_rtx_status = 8'hAE;
      cfg.max_length      = 16'd4096;
      phase               = SEEK_SYNC;
      byte_count          = 0;
      length_value        = '0;
      running_xor         = '0;
      carried_sum         = '0;
      current_type        = '0;
      for (int k = 0; k < slxd_pkg::HEADER_BYTES; k++) hdr_bytes[k] = '0;
      expected_events.delete();
      pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready)
        write_register(paddr[slxd_pkg::PADDR_W-1:2], pwdata);
      // drain before predicting: an event never leaves on the edge its byte enters
      if (m_tvalid_i && m_tready_i) compare_event();
      if (s_tvalid_i && s_tready_i) deframe_byte(s_tdata_i);
      pending_o = expected_events.size();
    end
  end

endmodule

FILE: dv/tb_sync_length_xor_packet_deframer.sv
`timescale 1ns / 1ps
// Top of the deframer testbench: clock, reset, register writes, byte stream and
// output back-pressure; deframer_event_checker does the prediction and comparison.

module tb_sync_length_xor_packet_deframer;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned IDLE_LIMIT     = 3000;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned PHASE_BYTES    = 50;
  localparam logic [slxd_pkg::REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [slxd_pkg::REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [slxd_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;
  logic                         s_tvalid_i;
  logic                         s_tready_o;
  logic [7:0]                   s_tdata_i;
  logic                         m_tvalid_o;
  logic                         m_tready_i;
  logic [63:0]                  m_tdata_o;
  logic [2:0]                   m_tuser_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned bytes_sent;
  int unsigned settings_count;
  int unsigned idle_cycles;
  int unsigned rx_hold_count = 0;
  logic        no_idle;
  logic [7:0]  cur_sync;
  logic [7:0]  cur_types [4];
  logic [15:0] cur_maxlen;

  sync_length_xor_packet_deframer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  deframer_event_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .s_tvalid_i   (s_tvalid_i),
    .s_tready_i   (s_tready_o),
    .s_tdata_i    (s_tdata_i),
    .m_tvalid_i   (m_tvalid_o),
    .m_tready_i   (m_tready_i),
    .m_tdata_i    (m_tdata_o),
    .m_tuser_i    (m_tuser_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Abort when no transfer of any kind happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) ||
                 (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_sync_length_xor_packet_deframer: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Output back-pressure: random gaps, one long hold on request
  initial begin
    int unsigned rx_wait;
    int unsigned rx_hold_seen;
    int unsigned r;
    m_tready_i   = 1'b0;
    rx_wait      = 0;
    rx_hold_seen = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_count != rx_hold_seen) begin
        rx_hold_seen = rx_hold_count;
        rx_wait      = RX_HOLD_CYCLES;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_tready_i <= 1'b0;
      end else if (no_idle) begin
        m_tready_i <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          m_tready_i <= 1'b1;
        end else begin
          m_tready_i <= 1'b0;
          rx_wait = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic is_type_code(input logic [7:0] b);
    return b == cur_types[0] || b == cur_types[1] || b == cur_types[2] || b == cur_types[3];
  endfunction

  // Hunting-time junk; never the sync byte, so each sequence stands alone
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8)       b = slxd_pkg::OLD_PREFIX_A;
    else if (r < 16) b = slxd_pkg::OLD_PREFIX_B;
    else             b = 8'($urandom);
    if (b == cur_sync) b ^= 8'h01;
    return b;
  endfunction

  function automatic logic [7:0] bad_type_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (is_type_code(b));
    return b;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= b;
    do @(posedge clk_i); while (!s_tready_o);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [slxd_pkg::REG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic [7:0] sync, input logic [7:0] t0,
                                input logic [7:0] t1, input logic [7:0] t2,
                                input logic [7:0] t3, input logic [15:0] maxlen);
    logic [31:0] junk;
    junk = $urandom;
    apb_write(slxd_pkg::REG_SYNC,       {junk[31:8], sync});
    apb_write(slxd_pkg::REG_TYPE_DATA,  {junk[31:8], t0});
    apb_write(slxd_pkg::REG_TYPE_DSTAT, {junk[31:8], t1});
    apb_write(slxd_pkg::REG_TYPE_CSTAT, {junk[31:8], t2});
    apb_write(slxd_pkg::REG_TYPE_RSTAT, {junk[31:8], t3});
    apb_write(slxd_pkg::REG_MAX_LEN,    {junk[31:16], maxlen});
    cur_sync     = sync;
    cur_types[0] = t0;
    cur_types[1] = t1;
    cur_types[2] = t2;
    cur_types[3] = t3;
    cur_maxlen   = maxlen;
    settings_count++;
  endtask

  // Send a framed packet; stop at the byte that ends it, completion or abort
  task automatic send_packet(input logic [15:0] len, input logic good_sum);
    logic [7:0]  pkt [$];
    logic [15:0] sum;
    int unsigned nbytes;
    int unsigned k;
    if (len == 0)                          nbytes = slxd_pkg::HEADER_BYTES;
    else if (len > slxd_pkg::HEADER_BYTES) nbytes = len;
    else                                   nbytes = slxd_pkg::HEADER_BYTES + 1;
    if (len > cur_maxlen && nbytes > cur_maxlen) nbytes = cur_maxlen;
    for (k = 0; k < nbytes; k++) pkt.push_back(8'($urandom));
    pkt[0] = cur_sync;
    pkt[1] = cur_types[$urandom_range(0, 3)];
    pkt[slxd_pkg::SIZE_OFFSET]     = len[15:8];
    pkt[slxd_pkg::SIZE_OFFSET + 1] = len[7:0];
    sum = {pkt[0], pkt[1]};
    for (k = 4; k < nbytes; k++) begin
      if (k < len) sum ^= k[0] ? {8'h00, pkt[k]} : {pkt[k], 8'h00};
    end
    if (good_sum) begin
      pkt[2] = sum[15:8];
      pkt[3] = sum[7:0];
    end
    foreach (pkt[k]) send_byte(pkt[k]);
  endtask

  task automatic send_random_sequence();
    int unsigned r;
    int unsigned r2;
    logic [15:0] len;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      r2 = $urandom_range(0, 99);
      if (r2 < 10)      len = 16'($urandom_range(1, slxd_pkg::HEADER_BYTES));
      else if (r2 < 85) len = 16'($urandom_range(slxd_pkg::HEADER_BYTES + 1, 40));
      else              len = 16'($urandom_range(41, 300));
      send_packet(len, $urandom_range(0, 99) < 65);
    end else if (r < 80) begin
      send_packet(16'h0000, 1'b1);
    end else if (r < 88) begin
      send_byte(cur_sync);
      send_byte(bad_type_byte());
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(noise_byte());
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned target;
    target = bytes_sent + count;
    while (bytes_sent < target) send_random_sequence();
  endtask

  initial begin
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    s_tvalid_i     = 1'b0;
    s_tdata_i      = '0;
    no_idle        = 1'b0;
    bytes_sent     = 0;
    settings_count = 1;
    cur_sync       = 8'hDA;
    cur_types[0]   = 8'hAB;
    cur_types[1]   = 8'hAC;
    cur_types[2]   = 8'hAD;
    cur_types[3]   = 8'hAE;
    cur_maxlen     = 16'd4096;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: hunting junk, bad type, zero length, short, odd and bad-sum packets
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(slxd_pkg::OLD_PREFIX_A);
    send_byte(slxd_pkg::OLD_PREFIX_B);
    send_byte(cur_sync);
    send_byte(8'h00);
    send_packet(16'd0, 1'b1);
    send_packet(16'd1, 1'b1);
    send_packet(16'd7, 1'b1);
    send_packet(16'd8, 1'b0);
    wait_drained();

    // Smallest length limit: completion on the limit, abort past it
    apply_settings(8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 16'd8);
    send_packet(16'd8, 1'b1);
    send_packet(16'd20, 1'b1);
    send_packet(16'd3, 1'b0);
    run_random(PHASE_BYTES);
    wait_drained();

    // Sync equal to an old prefix, largest limit, spare register addresses
    apply_settings(slxd_pkg::OLD_PREFIX_A, 8'h00, 8'hFF, slxd_pkg::OLD_PREFIX_B, 8'h55,
                   16'hFFFF);
    apb_write(REG_SPARE_A, $urandom);
    apb_write(REG_SPARE_B, $urandom);
    send_packet(16'd5, 1'b1);
    send_byte(slxd_pkg::OLD_PREFIX_B);
    send_packet(16'd48, 1'b1);
    run_random(PHASE_BYTES);
    wait_drained();

    // Long output hold while junk keeps coming, so the input backs up
    apply_settings(8'hFF, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   16'($urandom_range(16, 64)));
    rx_hold_count++;
    repeat (40) send_byte(noise_byte());
    wait_drained();
    run_random(PHASE_BYTES);
    wait_drained();

    // Back-to-back traffic, no gaps on either side
    no_idle = 1'b1;
    apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   16'($urandom_range(8, 300)));
    run_random(PHASE_BYTES);
    wait_drained();
    no_idle = 1'b0;

    apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   16'($urandom_range(slxd_pkg::HEADER_BYTES + 2, 4096)));
    run_random(PHASE_BYTES);
    wait_drained();

    $display("Sent %0d stream bytes under %0d register settings and checked %0d events,",
             bytes_sent, settings_count, checked);
    $display("with random gaps, a gap-free stretch and one long output hold.");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_sync_length_xor_packet_deframer: PASS");
    end else begin
      $display("tb_sync_length_xor_packet_deframer: FAIL");
    end
    $finish;
  end

endmodule
